// ===== hw/rtl/tdcp_pkg.sv =====
// Package for the tagged decimal channel parser.
// Holds the frame byte codes and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdcp_pkg;

  localparam int unsigned DefValueWidth = 32;

  localparam logic [7:0] ChStart = 8'h50;  // 'P'
  localparam logic [7:0] ChChanA = 8'h41;  // 'A'
  localparam logic [7:0] ChChanD = 8'h44;  // 'D'
  localparam logic [7:0] ChEnd   = 8'h21;  // '!'
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'

  localparam int unsigned DigitBase = 10;

endpackage

`default_nettype wire

// ===== hw/rtl/tdcp_intf.sv =====
// Valid/ready channel interfaces of the tagged decimal channel parser.
// Byte request channel and result request channel; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tdcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tdcp_res_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    channel;
  logic signed [VALUE_WIDTH-1:0] value_tenths;

  modport source (output valid, output channel, output value_tenths, input ready);
  modport sink   (input valid, input channel, input value_tenths, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdcp_in_reg.sv =====
// Input byte register of the tagged decimal channel parser.
// Decouples the byte channel from the parser stage; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module tdcp_in_reg (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  input  wire  [7:0] data_i,
  output logic       ready_o,
  input  wire        take_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic       valid_q;
  logic [7:0] data_q;

  // room when empty or when the held byte leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tdcp_core.sv =====
// Frame parser stage and result register of the tagged decimal channel parser.
// Uses byte codes from tdcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdcp_core #(
  parameter int unsigned VALUE_WIDTH = tdcp_pkg::DefValueWidth
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           byte_valid_i,
  input  wire  [7:0]                    byte_data_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [1:0]                    channel_o,
  output logic signed [VALUE_WIDTH-1:0] value_o
);

  localparam int unsigned MagW = VALUE_WIDTH - 1;
  localparam int unsigned ExtW = MagW + 4;

  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhGotP  = 2'd1;
  localparam logic [1:0] PhGotCh = 2'd2;
  localparam logic [1:0] PhNum   = 2'd3;

  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

  logic [1:0]      phase_q, phase_d;
  logic [1:0]      chan_q, chan_d;
  logic            neg_q, neg_d;
  logic            seen_q, seen_d;
  logic [MagW-1:0] mag_q, mag_d;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_chan_q;
  logic [VALUE_WIDTH-1:0] out_value_q;

  logic            emit;
  logic [7:0]      b;
  logic [7:0]      digit_off;
  logic [7:0]      chan_off;
  logic            is_digit;
  logic            is_chan;
  logic [ExtW-1:0] mag_ext;
  logic [ExtW-1:0] mag_next;
  logic            mag_sat;
  logic [VALUE_WIDTH-1:0] mag_val;
  logic [VALUE_WIDTH-1:0] signed_val;

  assign b         = byte_data_i;
  assign digit_off = b - tdcp_pkg::ChZero;
  assign chan_off  = b - tdcp_pkg::ChChanA;
  assign is_digit  = (b >= tdcp_pkg::ChZero) && (b <= tdcp_pkg::ChNine);
  assign is_chan   = (b >= tdcp_pkg::ChChanA) && (b <= tdcp_pkg::ChChanD);

  // mag*10 + d, saturate when it passes the largest magnitude
  assign mag_ext  = {4'b0, mag_q};
  assign mag_next = (mag_ext << 3) + (mag_ext << 1) + ExtW'(digit_off[3:0]);
  assign mag_sat  = mag_next > {4'b0, MagMax};

  assign mag_val    = {1'b0, mag_q};
  assign signed_val = neg_q ? (~mag_val + VALUE_WIDTH'(1)) : mag_val;

  assign take_o = byte_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    mag_d   = mag_q;
    emit    = 1'b0;

    // letter, '-', digit or valid end go first; else 'P' restarts, else idle
    if ((phase_q == PhGotP) && is_chan) begin
      chan_d  = chan_off[1:0];
      phase_d = PhGotCh;
    end else if ((phase_q == PhGotCh) && (b == tdcp_pkg::ChMinus)) begin
      neg_d   = 1'b1;
      phase_d = PhNum;
    end else if (((phase_q == PhGotCh) || (phase_q == PhNum)) && is_digit) begin
      mag_d   = mag_sat ? MagMax : mag_next[MagW-1:0];
      seen_d  = 1'b1;
      phase_d = PhNum;
    end else if ((phase_q == PhNum) && (b == tdcp_pkg::ChEnd) && seen_q) begin
      emit    = 1'b1;
      phase_d = PhIdle;
    end else if (b == tdcp_pkg::ChStart) begin
      phase_d = PhGotP;
      chan_d  = 2'd0;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      mag_d   = '0;
    end else begin
      phase_d = PhIdle;
    end
  end

  always_comb begin
    if (take_o) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      chan_q      <= 2'd0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q <= phase_d;
        chan_q  <= chan_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        mag_q   <= mag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      out_chan_q  <= chan_q;
      out_value_q <= signed_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = out_chan_q;
  assign value_o     = out_value_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tagged_decimal_channel_parser.sv =====
// Top level of the tagged decimal channel parser.
// Depends on tdcp_pkg, tdcp_intf (channel interfaces), tdcp_in_reg and tdcp_core.
//
// Parses a byte stream for frames 'P', channel letter A..D, an optional '-'
// right after the letter, one or more decimal digits, then '!'. Each complete
// frame yields one result request: the channel (0=A .. 3=D) and the signed
// value in tenths, two's complement of VALUE_WIDTH bits, with the magnitude
// saturated at 2^(VALUE_WIDTH-1)-1. A malformed byte ends the frame and is
// checked again as a start 'P'. One byte is taken every cycle while no result
// is stalled; a result is valid once its '!' byte has passed from the input
// byte register through the parser into the result register.
// A stalled result holds the parser, and the input register absorbs one more
// byte meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module tagged_decimal_channel_parser #(
  parameter int unsigned VALUE_WIDTH = tdcp_pkg::DefValueWidth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tdcp_byte_if.sink   data_i,
  tdcp_res_if.source  result_o
);

  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       res_valid;
  logic [1:0] res_chan;
  logic signed [VALUE_WIDTH-1:0] res_value;

  tdcp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (data_i.valid),
    .data_i  (data_i.data_byte),
    .ready_o (data_i.ready),
    .take_i  (take),
    .valid_o (byte_valid),
    .data_o  (byte_data)
  );

  tdcp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_data_i  (byte_data),
    .take_o       (take),
    .out_valid_o  (res_valid),
    .out_ready_i  (result_o.ready),
    .channel_o    (res_chan),
    .value_o      (res_value)
  );

  assign result_o.valid        = res_valid;
  assign result_o.channel      = res_chan;
  assign result_o.value_tenths = res_value;

endmodule

`default_nettype wire
